// ----- src/icmp_prc_pkg.sv -----
package icmp_prc_pkg;

    localparam int MAX_PACKET_BYTES = 1500;
    localparam int CNT_W            = 11;
    localparam int HLEN_W           = 6;
    localparam int PORT_W           = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int FIFO_DEPTH       = 2;
    localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] TYPE_TIME_EXCEEDED    = 8'd11;
    localparam logic [7:0] TYPE_UNREACHABLE      = 8'd3;
    localparam logic [7:0] CODE_IN_TRANSIT       = 8'd0;
    localparam logic [7:0] CODE_PORT_UNREACHABLE = 8'd3;
    localparam logic [7:0] PROTO_UDP             = 8'd17;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE   = 1'b1;

    localparam logic [PORT_W-1:0] DEST_BASE_RESET = 16'd33434;

    localparam logic [1:0] VERDICT_NONE        = 2'd0;
    localparam logic [1:0] VERDICT_ROUTER      = 2'd1;
    localparam logic [1:0] VERDICT_REACHED     = 2'd2;
    localparam logic [1:0] VERDICT_UNREACHABLE = 2'd3;

    // one finished packet, as captured by the front end
    typedef struct packed {
        logic [CNT_W-1:0]  n_bytes;
        logic [HLEN_W-1:0] outer_len;
        logic [7:0]        msg_type;
        logic [7:0]        msg_code;
        logic [HLEN_W-1:0] inner_len;
        logic [7:0]        inner_proto;
        logic [PORT_W-1:0] udp_src;
        logic [PORT_W-1:0] udp_dst;
        logic [PORT_W-1:0] seq;
    } pkt_rec_t;

endpackage

// ----- src/icmp_prc_front.sv -----
module icmp_prc_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  logic [15:0]              probe_seq,
    output logic                     push,
    output icmp_prc_pkg::pkt_rec_t   rec
);

    localparam int CW = icmp_prc_pkg::CNT_W;
    localparam int HW = icmp_prc_pkg::HLEN_W;
    localparam int PW = icmp_prc_pkg::PORT_W;

    logic [CW-1:0] count_reg, count_next;
    logic [HW-1:0] ohl_reg, ohl_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    code_reg, code_next;
    logic [HW-1:0] ihl_reg, ihl_next;
    logic [7:0]    proto_reg, proto_next;
    logic [PW-1:0] src_reg, src_next;
    logic [PW-1:0] dst_reg, dst_next;
    logic [PW-1:0] seq_reg, seq_next;

    logic          in_range;
    logic          first;
    logic [HW-1:0] h1;
    logic [CW-1:0] base2;
    logic [CW-1:0] ports;
    logic [CW-1:0] n_bytes;
    logic [HW-1:0] ohl_upd, ihl_upd;
    logic [7:0]    type_upd, code_upd, proto_upd;
    logic [PW-1:0] src_upd, dst_upd, seq_upd;
    logic          take;

    assign in_range = count_reg < CW'(icmp_prc_pkg::MAX_PACKET_BYTES);
    assign first    = count_reg == '0;
    assign take     = accept && in_range;
    assign n_bytes  = in_range ? count_reg + CW'(1) : count_reg;

    always_comb
    begin
        // first byte clears every other capture, takes the probe sequence and sets the outer length at once
        ohl_upd   = first ? {data_byte[3:0], 2'b00} : ohl_reg;
        seq_upd   = first ? probe_seq : seq_reg;
        type_upd  = first ? 8'd0 : type_reg;
        code_upd  = first ? 8'd0 : code_reg;
        ihl_upd   = first ? '0 : ihl_reg;
        proto_upd = first ? 8'd0 : proto_reg;
        src_upd   = first ? '0 : src_reg;
        dst_upd   = first ? '0 : dst_reg;

        h1    = ohl_upd;
        base2 = CW'(h1) + CW'(8);

        if (count_reg == CW'(h1))
        begin
            type_upd = data_byte;
        end
        if (count_reg == CW'(h1) + CW'(1))
        begin
            code_upd = data_byte;
        end
        if (count_reg == base2)
        begin
            ihl_upd = {data_byte[3:0], 2'b00};
        end
        if (count_reg == base2 + CW'(9))
        begin
            proto_upd = data_byte;
        end

        ports = base2 + CW'(ihl_upd);
        if (count_reg == ports)
        begin
            src_upd = {data_byte, src_upd[7:0]};
        end
        if (count_reg == ports + CW'(1))
        begin
            src_upd = {src_upd[15:8], data_byte};
        end
        if (count_reg == ports + CW'(2))
        begin
            dst_upd = {data_byte, dst_upd[7:0]};
        end
        if (count_reg == ports + CW'(3))
        begin
            dst_upd = {dst_upd[15:8], data_byte};
        end
    end

    always_comb
    begin
        ohl_next   = take ? ohl_upd   : ohl_reg;
        type_next  = take ? type_upd  : type_reg;
        code_next  = take ? code_upd  : code_reg;
        ihl_next   = take ? ihl_upd   : ihl_reg;
        proto_next = take ? proto_upd : proto_reg;
        src_next   = take ? src_upd   : src_reg;
        dst_next   = take ? dst_upd   : dst_reg;
        seq_next   = take ? seq_upd   : seq_reg;

        count_next = count_reg;
        if (accept)
        begin
            count_next = last_byte ? '0 : n_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ohl_reg   <= '0;
            type_reg  <= '0;
            code_reg  <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ohl_reg   <= ohl_next;
            type_reg  <= type_next;
            code_reg  <= code_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            seq_reg   <= seq_next;
        end
    end

    assign push = accept && last_byte;

    always_comb
    begin
        rec.n_bytes     = n_bytes;
        rec.outer_len   = ohl_next;
        rec.msg_type    = type_next;
        rec.msg_code    = code_next;
        rec.inner_len   = ihl_next;
        rec.inner_proto = proto_next;
        rec.udp_src     = src_next;
        rec.udp_dst     = dst_next;
        rec.seq         = seq_next;
    end

endmodule

// ----- src/icmp_prc_fifo.sv -----
module icmp_prc_fifo
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  icmp_prc_pkg::pkt_rec_t   push_rec,
    output logic                     full,
    input  logic                     pop,
    output logic                     not_empty,
    output icmp_prc_pkg::pkt_rec_t   pop_rec
);

    localparam int PTR_W = icmp_prc_pkg::FIFO_PTR_W;
    localparam int CNT_W = icmp_prc_pkg::FIFO_CNT_W;

    icmp_prc_pkg::pkt_rec_t mem_reg [icmp_prc_pkg::FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = fill_reg == CNT_W'(icmp_prc_pkg::FIFO_DEPTH);
    assign not_empty = fill_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- src/icmp_prc_back.sv -----
module icmp_prc_back
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [icmp_prc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [icmp_prc_pkg::PORT_W-1:0]         cfg_data,
    input  logic                                    rec_valid,
    input  icmp_prc_pkg::pkt_rec_t                  rec,
    output logic                                    pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [1:0]                              verdict,
    output logic [7:0]                              icmp_code_out
);

    localparam int CW = icmp_prc_pkg::CNT_W;
    localparam int PW = icmp_prc_pkg::PORT_W;

    logic [PW-1:0] src_port_reg, src_port_next;
    logic [PW-1:0] dst_base_reg, dst_base_next;
    logic          valid_reg, valid_next;
    logic [1:0]    verdict_reg, verdict_next;
    logic [7:0]    code_reg, code_next;

    logic          long_enough;
    logic [CW-1:0] icmp_len;
    logic          te, un, len_ok, match;
    logic [PW-1:0] want_dst;
    logic [1:0]    v;
    logic [7:0]    c;

    always_comb
    begin
        src_port_next = src_port_reg;
        dst_base_next = dst_base_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                icmp_prc_pkg::CFG_SOURCE_PORT: src_port_next = cfg_data;
                icmp_prc_pkg::CFG_DEST_BASE:   dst_base_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        long_enough = {1'b0, rec.n_bytes} >= (CW+1)'(rec.outer_len) + (CW+1)'(8);
        icmp_len    = rec.n_bytes - CW'(rec.outer_len);
        te          = rec.msg_type == icmp_prc_pkg::TYPE_TIME_EXCEEDED &&
                      rec.msg_code == icmp_prc_pkg::CODE_IN_TRANSIT;
        un          = rec.msg_type == icmp_prc_pkg::TYPE_UNREACHABLE;
        len_ok      = icmp_len >= CW'(28) && icmp_len >= CW'(rec.inner_len) + CW'(12);
        want_dst    = dst_base_reg + rec.seq;
        match       = rec.inner_proto == icmp_prc_pkg::PROTO_UDP &&
                      rec.udp_src == src_port_reg && rec.udp_dst == want_dst;

        v = icmp_prc_pkg::VERDICT_NONE;
        c = 8'd0;
        if (long_enough && (te || un) && len_ok && match)
        begin
            if (te)
            begin
                v = icmp_prc_pkg::VERDICT_ROUTER;
            end
            else if (rec.msg_code == icmp_prc_pkg::CODE_PORT_UNREACHABLE)
            begin
                v = icmp_prc_pkg::VERDICT_REACHED;
            end
            else
            begin
                v = icmp_prc_pkg::VERDICT_UNREACHABLE;
                c = rec.msg_code;
            end
        end
    end

    // output register refills in the cycle it is drained
    assign pop = rec_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next   = valid_reg;
        verdict_next = verdict_reg;
        code_next    = code_reg;
        if (pop)
        begin
            valid_next   = 1'b1;
            verdict_next = v;
            code_next    = c;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_reg <= '0;
            dst_base_reg <= icmp_prc_pkg::DEST_BASE_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            src_port_reg <= src_port_next;
            dst_base_reg <= dst_base_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        code_reg    <= code_next;
    end

    assign out_valid     = valid_reg;
    assign verdict       = verdict_reg;
    assign icmp_code_out = code_reg;

endmodule

// ----- src/icmp_probe_reply_classifier.sv -----
// Throughput: one byte per cycle; in_ready drops only while both queue slots hold
//   finished packets that the output side has not yet taken.
// Path: the last byte's transfer writes the packet into the queue; the classify stage then loads it
//   into the output register, raising out_valid, once that register is empty or being drained.
// Reset: rst_n clears counters, captures, queue and output valid; source_port resets
//   to 0 and dest_port_base to 33434.
module icmp_probe_reply_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [icmp_prc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icmp_prc_pkg::PORT_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    input  logic [15:0]                         probe_seq,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          verdict,
    output logic [7:0]                          icmp_code_out
);

    icmp_prc_pkg::pkt_rec_t push_rec, pop_rec;
    logic push, full, pop, not_empty, accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    icmp_prc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .probe_seq (probe_seq),
        .push      (push),
        .rec       (push_rec)
    );

    icmp_prc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_rec   (pop_rec)
    );

    icmp_prc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rec_valid     (not_empty),
        .rec           (pop_rec),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .verdict       (verdict),
        .icmp_code_out (icmp_code_out)
    );

endmodule

// ----- verif/icmp_probe_reply_classifier_tb.sv -----
`timescale 1ns / 1ps

module icmp_probe_reply_classifier_tb;

    import icmp_prc_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [15:0] seq;
    } byte_beat_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] code;
    } reply_class_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [PORT_W-1:0]    cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic [7:0]           data_byte     = '0;
    logic                 last_byte     = 1'b0;
    logic [15:0]          probe_seq     = '0;
    logic                 out_ready     = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [1:0]           verdict;
    logic [7:0]           icmp_code_out;

    icmp_probe_reply_classifier dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .probe_seq     (probe_seq),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .verdict       (verdict),
        .icmp_code_out (icmp_code_out)
    );

    always #4 clk = ~clk;

    byte_beat_t   pending_bytes[$];
    reply_class_t expected_verdicts[$];
    int           bytes_queued = 0;
    int           fail_count   = 0;
    int           results_seen = 0;

    // register copies
    logic [15:0] cfg_sport = '0;
    logic [15:0] cfg_dbase = DEST_BASE_RESET;

    // capture state of the packet in progress
    logic [CNT_W-1:0]  rx_count   = '0;
    logic [HLEN_W-1:0] ihl_outer  = '0;
    logic [HLEN_W-1:0] ihl_inner  = '0;
    logic [7:0]        cap_type   = '0;
    logic [7:0]        cap_code   = '0;
    logic [7:0]        cap_proto  = '0;
    logic [15:0]       cap_sport  = '0;
    logic [15:0]       cap_dport  = '0;
    logic [15:0]       cap_seq    = '0;

    function automatic reply_class_t classify_packet(input int n);
        reply_class_t res;
        logic         te;
        logic         un;
        int           icmp_len;
        logic [15:0]  want_dport;
        res.kind   = VERDICT_NONE;
        res.code   = 8'd0;
        want_dport = cfg_dbase + cap_seq;
        if (n >= int'(ihl_outer) + 8)
        begin
            icmp_len = n - int'(ihl_outer);
            te = (cap_type == TYPE_TIME_EXCEEDED) && (cap_code == CODE_IN_TRANSIT);
            un = (cap_type == TYPE_UNREACHABLE);
            if ((te || un) && icmp_len >= 28 && icmp_len >= 12 + int'(ihl_inner) &&
                cap_proto == PROTO_UDP && cap_sport == cfg_sport && cap_dport == want_dport)
            begin
                if (te)
                    res.kind = VERDICT_ROUTER;
                else if (cap_code == CODE_PORT_UNREACHABLE)
                    res.kind = VERDICT_REACHED;
                else
                begin
                    res.kind = VERDICT_UNREACHABLE;
                    res.code = cap_code;
                end
            end
        end
        return res;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic last, input logic [15:0] seq);
        int pos;
        int h1;
        int b2;
        int pp;
        if (rx_count < MAX_PACKET_BYTES)
        begin
            pos = rx_count;
            if (pos == 0)
            begin
                cap_seq   = seq;
                ihl_outer = {b[3:0], 2'b00};
                cap_type  = '0;
                cap_code  = '0;
                ihl_inner = '0;
                cap_proto = '0;
                cap_sport = '0;
                cap_dport = '0;
            end
            // offsets follow whatever was captured up to and including this byte
            h1 = ihl_outer;
            b2 = h1 + 8;
            if (pos == h1)     cap_type  = b;
            if (pos == h1 + 1) cap_code  = b;
            if (pos == b2)     ihl_inner = {b[3:0], 2'b00};
            if (pos == b2 + 9) cap_proto = b;
            pp = b2 + int'(ihl_inner);
            if (pos == pp)     cap_sport[15:8] = b;
            if (pos == pp + 1) cap_sport[7:0]  = b;
            if (pos == pp + 2) cap_dport[15:8] = b;
            if (pos == pp + 3) cap_dport[7:0]  = b;
            rx_count = rx_count + 1'b1;
        end
        if (last)
        begin
            expected_verdicts.push_back(classify_packet(rx_count));
            rx_count = '0;
        end
    endtask

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] probe_port(input logic [15:0] seq);
        return cfg_dbase + seq;
    endfunction

    // len of 0 gives the natural length of header, quote and UDP header plus extra
    task automatic queue_packet(input logic [3:0] ohl, input logic [7:0] itype,
                                input logic [7:0] icode, input logic [3:0] iihl,
                                input logic [7:0] proto, input logic [15:0] sport,
                                input logic [15:0] dport, input int len, input int extra,
                                input logic [15:0] seq);
        logic [7:0] pkt[$];
        byte_beat_t beat;
        int         h1;
        int         b2;
        int         pp;
        int         total;
        h1    = int'(ohl) * 4;
        b2    = h1 + 8;
        pp    = b2 + int'(iihl) * 4;
        total = (len > 0) ? len : pp + 8 + extra;
        for (int i = 0; i < total; i++)
            pkt.push_back(8'($urandom));
        pkt[0] = {4'h4, ohl};
        if (h1 < total)     pkt[h1]     = itype;
        if (h1 + 1 < total) pkt[h1 + 1] = icode;
        if (b2 < total)     pkt[b2]     = {4'h4, iihl};
        if (b2 + 9 < total) pkt[b2 + 9] = proto;
        if (pp < total)     pkt[pp]     = sport[15:8];
        if (pp + 1 < total) pkt[pp + 1] = sport[7:0];
        if (pp + 2 < total) pkt[pp + 2] = dport[15:8];
        if (pp + 3 < total) pkt[pp + 3] = dport[7:0];
        for (int i = 0; i < total; i++)
        begin
            beat.data = pkt[i];
            beat.last = (i == total - 1);
            // only the first byte's sequence counts
            beat.seq  = (i == 0) ? seq : 16'($urandom);
            pending_bytes.push_back(beat);
        end
        bytes_queued += total;
    endtask

    task automatic queue_random_packet();
        int          r;
        int          sel;
        int          extra;
        int          len;
        logic [3:0]  ohl;
        logic [3:0]  iihl;
        logic [7:0]  itype;
        logic [7:0]  icode;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] seq;
        r     = $urandom_range(0, 99);
        seq   = 16'($urandom);
        sel   = $urandom_range(0, 9);
        itype = (sel < 3 || sel == 7) ? TYPE_TIME_EXCEEDED :
                (sel == 8) ? 8'($urandom) : TYPE_UNREACHABLE;
        icode = (sel < 3) ? CODE_IN_TRANSIT :
                (sel < 5) ? CODE_PORT_UNREACHABLE : 8'($urandom_range(0, 15));
        if (sel == 8)
            icode = 8'($urandom);
        proto = ($urandom_range(0, 9) != 0) ? PROTO_UDP : 8'($urandom);
        sport = ($urandom_range(0, 9) != 0) ? cfg_sport : 16'($urandom);
        dport = probe_port(seq);
        if ($urandom_range(0, 7) == 0)
            dport = dport + 16'($urandom_range(1, 3));
        extra = $urandom_range(0, 12);
        if (r < 85)
        begin
            ohl  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            iihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            len  = 0;
            if (r >= 70)
                len = $urandom_range(1, int'(ohl) * 4 + int'(iihl) * 4 + 16 + extra);
        end
        else
        begin
            // tiny header lengths, fields land on shared bytes
            ohl  = 4'($urandom_range(0, 4));
            iihl = 4'($urandom_range(0, 15));
            len  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 80) : 0;
        end
        queue_packet(ohl, itype, icode, iihl, proto, sport, dport, len, extra, seq);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_SOURCE_PORT)
            cfg_sport = value;
        else
            cfg_dbase = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender
    int send_gap  = 0;
    int send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        byte_beat_t beat;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
            probe_seq <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_byte(data_byte, last_byte, probe_seq);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    beat = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= beat.data;
                    last_byte <= beat.last;
                    probe_seq <= beat.seq;
                    send_gap  = pick_gap(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    int recv_gap  = 0;
    int recv_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        reply_class_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected transfer, verdict %0d code %0d",
                             $time, verdict, icmp_code_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict !== want.kind)
                    begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.kind, verdict);
                        fail_count++;
                    end
                    if (icmp_code_out !== want.code)
                    begin
                        $display("%0t: icmp_code_out expected %0d actual %0d",
                                 $time, want.code, icmp_code_out);
                        fail_count++;
                    end
                end
                results_seen++;
            end
            // one long stall mid-run so the block backs up onto its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 60)
            begin
                hold_done = 1'b1;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  = pick_gap(recv_calm);
            end
        end
    end

    initial
    begin
        int start_bytes;
        int n_pkts;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        queue_packet(5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 5, PROTO_UDP, cfg_sport,
                     probe_port(7), 0, 0, 16'd7);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 5, PROTO_UDP, cfg_sport,
                     probe_port(0), 0, 4, 16'd0);
        queue_packet(5, TYPE_UNREACHABLE, 8'd0, 5, PROTO_UDP, cfg_sport,
                     probe_port(100), 0, 0, 16'd100);
        queue_packet(5, TYPE_UNREACHABLE, 8'd255, 5, PROTO_UDP, cfg_sport,
                     probe_port(16'hFFFF), 0, 0, 16'hFFFF);
        queue_packet(5, TYPE_TIME_EXCEEDED, 8'd1, 5, PROTO_UDP, cfg_sport,
                     probe_port(3), 0, 0, 16'd3);
        queue_packet(5, 8'd0, 8'd0, 5, PROTO_UDP, cfg_sport, probe_port(3), 0, 0, 16'd3);
        queue_packet(5, 8'd255, CODE_PORT_UNREACHABLE, 5, PROTO_UDP, cfg_sport,
                     probe_port(3), 0, 0, 16'd3);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 5, 8'd6, cfg_sport,
                     probe_port(4), 0, 0, 16'd4);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 5, PROTO_UDP,
                     cfg_sport + 16'd1, probe_port(5), 0, 0, 16'd5);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 5, PROTO_UDP, cfg_sport,
                     probe_port(5) + 16'd1, 0, 0, 16'd5);
        // truncated: single byte, too short for the ICMP header, one byte short of the natural length
        queue_packet(5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 5, PROTO_UDP, cfg_sport,
                     probe_port(2), 1, 0, 16'd2);
        queue_packet(5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 5, PROTO_UDP, cfg_sport,
                     probe_port(2), 27, 0, 16'd2);
        queue_packet(5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 5, PROTO_UDP, cfg_sport,
                     probe_port(2), 55, 0, 16'd2);
        // ICMP length one short of 28, then exactly 28
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 1, PROTO_UDP, cfg_sport,
                     probe_port(9), 47, 0, 16'd9);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 1, PROTO_UDP, cfg_sport,
                     probe_port(9), 48, 0, 16'd9);
        // header length extremes
        queue_packet(15, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 15, PROTO_UDP, cfg_sport,
                     probe_port(11), 0, 0, 16'd11);
        queue_packet(0, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 5, PROTO_UDP, cfg_sport,
                     probe_port(1), 0, 0, 16'd1);
        queue_packet(1, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 0, PROTO_UDP, cfg_sport,
                     probe_port(1), 0, 0, 16'd1);
        queue_packet(4, TYPE_UNREACHABLE, 8'd1, 2, PROTO_UDP, cfg_sport,
                     probe_port(1), 0, 0, 16'd1);
        // overlong: exactly at the limit, one past, well past
        queue_packet(5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 5, PROTO_UDP, cfg_sport,
                     probe_port(12), MAX_PACKET_BYTES, 0, 16'd12);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 5, PROTO_UDP, cfg_sport,
                     probe_port(13), MAX_PACKET_BYTES + 1, 0, 16'd13);
        queue_packet(5, TYPE_UNREACHABLE, 8'd7, 5, PROTO_UDP, cfg_sport,
                     probe_port(14), MAX_PACKET_BYTES + 40, 0, 16'd14);
        wait_idle();

        write_reg(CFG_SOURCE_PORT, 16'hFFFF);
        write_reg(CFG_DEST_BASE, 16'hFFFF);
        // base plus sequence wraps to zero
        queue_packet(5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 5, PROTO_UDP, cfg_sport,
                     probe_port(1), 0, 0, 16'd1);
        repeat (15) queue_random_packet();
        wait_idle();

        write_reg(CFG_SOURCE_PORT, 16'h0000);
        write_reg(CFG_DEST_BASE, 16'h0000);
        // zero ports match the captures, written or untouched; only the inner length rule decides
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 15, PROTO_UDP, 16'd0,
                     16'd0, 60, 0, 16'd0);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 15, PROTO_UDP, 16'd0,
                     16'd0, 91, 0, 16'd0);
        queue_packet(5, TYPE_UNREACHABLE, CODE_PORT_UNREACHABLE, 15, PROTO_UDP, 16'd0,
                     16'd0, 92, 0, 16'd0);
        repeat (15) queue_random_packet();
        wait_idle();

        write_reg(CFG_SOURCE_PORT, 16'($urandom));
        write_reg(CFG_DEST_BASE, 16'($urandom));
        start_bytes = bytes_queued;
        n_pkts      = 0;
        while (n_pkts < 40 || bytes_queued - start_bytes < 400)
        begin
            queue_random_packet();
            n_pkts++;
        end
        wait_idle();
        repeat (10) @(posedge clk);

        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
